// ===== rtl/ecf_pkg.sv =====
// Shared types and constants for the eased screen crossfade pixel block.
// Holds the item structs, register indexes and reset values.
// No dependencies.
package ecf_pkg;

  localparam int unsigned CLR_W      = 8;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned FRAC_W_DEF = 16;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CLR_W-1:0] CLR_MAX      = '1;
  localparam logic [DUR_W-1:0] DUR_RESET    = 16'd1000;
  localparam logic             MODE_QUINTIC = 1'b1;
  localparam logic             MODE_RESET   = MODE_QUINTIC;

  typedef enum logic [0:0] {
    REG_DURATION = 1'b0,
    REG_MODE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0] elapsed_ms;
    logic [CLR_W-1:0] from_red;
    logic [CLR_W-1:0] from_green;
    logic [CLR_W-1:0] from_blue;
    logic [CLR_W-1:0] to_red;
    logic [CLR_W-1:0] to_green;
    logic [CLR_W-1:0] to_blue;
  } in_item_t;

  typedef struct packed {
    logic [CLR_W-1:0] out_red;
    logic [CLR_W-1:0] out_green;
    logic [CLR_W-1:0] out_blue;
    logic             done_res;
  } out_item_t;

endpackage

// ===== rtl/ecf_div_pipe.sv =====
// Pipelined restoring divider: progress = elapsed*2^F / duration.
// One quotient bit per stage.
// Depends on ecf_pkg.
module ecf_div_pipe #(
  parameter int unsigned FRACTION_BITS = ecf_pkg::FRAC_W_DEF,
  parameter int unsigned SIDE_W        = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [ecf_pkg::DUR_W-1:0] in_elapsed,
  input  logic [ecf_pkg::DUR_W-1:0] in_dur,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [FRACTION_BITS-1:0]  out_p,
  output logic [SIDE_W-1:0]         out_side
);
  import ecf_pkg::*;

  localparam int unsigned STEPS = DUR_W + FRACTION_BITS;

  // index s is the input of stage s; the dividend shifts out on top while
  // quotient bits shift in at the bottom of the same register
  logic                          vld_s  [STEPS+1];
  logic [STEPS-1:0]              dq_p   [STEPS+1];
  logic [SIDE_W-1:0]             side_s [STEPS+1];
  logic [DUR_W-1:0]              rem_p  [STEPS];
  logic [DUR_W-1:0]              dur_s  [STEPS];

  assign vld_s[0]  = in_valid;
  assign dq_p[0]   = {in_elapsed, {FRACTION_BITS{1'b0}}};
  assign side_s[0] = in_side;
  assign rem_p[0]  = '0;
  assign dur_s[0]  = in_dur;

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic [DUR_W:0]        shp;
    logic [DUR_W:0]        difp;
    logic                  gep;

    assign shp  = {rem_p[s], dq_p[s][STEPS-1]};
    assign gep  = shp >= {1'b0, dur_s[s]};
    assign difp = shp - {1'b0, dur_s[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s[s+1] <= 1'b0;
      end else if (adv) begin
        vld_s[s+1] <= vld_s[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dq_p[s+1]   <= {dq_p[s][STEPS-2:0], gep};
        side_s[s+1] <= side_s[s];
      end
    end

    // the last stage keeps only the quotient
    if (s + 1 < STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_p[s+1] <= gep ? difp[DUR_W-1:0] : shp[DUR_W-1:0];
          dur_s[s+1] <= dur_s[s];
        end
      end
    end
  end

  assign out_valid = vld_s[STEPS];
  assign out_p     = dq_p[STEPS][FRACTION_BITS-1:0];
  assign out_side  = side_s[STEPS];

endmodule

// ===== rtl/ecf_weight.sv =====
// Weight pipeline: quintic smoothstep of progress (or progress itself) and
// the screen pull factor 4*w*(1-w), four register stages.
// Depends on ecf_pkg.
module ecf_weight #(
  parameter int unsigned FRACTION_BITS = ecf_pkg::FRAC_W_DEF,
  parameter int unsigned SIDE_W        = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [FRACTION_BITS-1:0] in_p,
  input  logic                     in_mode,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [FRACTION_BITS:0]   out_w,
  output logic [FRACTION_BITS:0]   out_mid,
  output logic [SIDE_W-1:0]        out_side
);
  import ecf_pkg::*;

  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned SQ_W  = 2*F + 1;
  localparam int unsigned KW    = F + 5;
  localparam int unsigned WP_W  = F + KW + 1;
  localparam int unsigned MD_W  = 2*F + 5;
  localparam logic [F:0]  ONE   = (F+1)'(1) << F;
  localparam logic [KW:0] ONE_K = (KW+1)'(1) << F;

  logic [3:0]        vld_r;
  logic [SIDE_W-1:0] side1_r, side2_r, side3_r, side4_r;

  // stage 1: p^2
  logic [F-1:0]  p1_r, t2_r;
  logic          mode1_r;
  logic [SQ_W-1:0] sq_nxt;
  // stage 2: p^3 and the polynomial factor
  logic [F-1:0]  p2_r, t3_r;
  logic [KW-1:0] k_r;
  logic          mode2_r;
  logic [SQ_W-1:0] cube_nxt;
  logic [KW-1:0] kpos, kneg;
  // stage 3: weight
  logic [F:0]    w3_r, w_nxt;
  logic [WP_W-1:0] wp;
  logic [KW:0]   wq;
  // stage 4: pull factor
  logic [F:0]    w4_r, mid_r, mid_nxt;
  logic [MD_W-1:0] md;
  logic [F+4:0]  midq;

  always_comb begin
    sq_nxt   = SQ_W'(in_p) * SQ_W'(in_p) + (SQ_W'(1) << (F - 1));
    cube_nxt = SQ_W'(t2_r) * SQ_W'(p1_r) + (SQ_W'(1) << (F - 1));
    kpos     = KW'(6) * KW'(t2_r) + (KW'(10) << F);
    kneg     = KW'(15) * KW'(p1_r);
    wp       = WP_W'(t3_r) * WP_W'(k_r) + (WP_W'(1) << (F - 1));
    wq       = wp[WP_W-1:F];
    if (mode2_r == MODE_QUINTIC) begin
      w_nxt = (wq > ONE_K) ? ONE : wq[F:0];
    end else begin
      w_nxt = {1'b0, p2_r};
    end
    md      = ((MD_W'(w3_r) * MD_W'(ONE - w3_r)) << 2) + (MD_W'(1) << (F - 1));
    midq    = md[MD_W-1:F];
    mid_nxt = (midq > (F+5)'(ONE)) ? ONE : midq[F:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= in_p;
      t2_r    <= sq_nxt[2*F-1:F];
      mode1_r <= in_mode;
      side1_r <= in_side;

      p2_r    <= p1_r;
      t3_r    <= cube_nxt[2*F-1:F];
      k_r     <= (kpos >= kneg) ? kpos - kneg : '0;
      mode2_r <= mode1_r;
      side2_r <= side1_r;

      w3_r    <= w_nxt;
      side3_r <= side2_r;

      w4_r    <= w3_r;
      mid_r   <= mid_nxt;
      side4_r <= side3_r;
    end
  end

  assign out_valid = vld_r[3];
  assign out_w     = w4_r;
  assign out_mid   = mid_r;
  assign out_side  = side4_r;

endmodule

// ===== rtl/ecf_blend.sv =====
// Per-channel blend: linear mix, screen term, pull toward screen, clamp and
// round. Four register stages, the last one is the output register.
// Depends on ecf_pkg.
module ecf_blend #(
  parameter int unsigned FRACTION_BITS = ecf_pkg::FRAC_W_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          adv,
  input  logic                                          in_valid,
  input  logic [FRACTION_BITS:0]                        in_w,
  input  logic [FRACTION_BITS:0]                        in_mid,
  input  logic [2:0][ecf_pkg::CLR_W-1:0]                in_from,
  input  logic [2:0][ecf_pkg::CLR_W-1:0]                in_to,
  input  logic [2:0][ecf_pkg::CLR_W+FRACTION_BITS-1:0]  in_q,
  input  logic                                          in_done,
  output logic                                          out_valid,
  output ecf_pkg::out_item_t                            out_item
);
  import ecf_pkg::*;

  localparam int unsigned F      = FRACTION_BITS;
  localparam int unsigned LIN_W  = CLR_W + F + 2;
  localparam int unsigned SCR_W  = CLR_W + F + 1;
  localparam int unsigned PROD_W = SCR_W + F + 1;
  localparam int unsigned OUT_W  = CLR_W + F + 4;
  localparam logic [F:0]  ONE    = (F+1)'(1) << F;
  localparam logic [OUT_W-1:0] LIM  = OUT_W'(CLR_MAX) << F;
  localparam logic [OUT_W-1:0] HALF = OUT_W'(1) << (F - 1);

  logic [3:0] vld_r;

  logic [2:0][LIN_W-1:0]  lin1_r, lin2_r, lin3_r, lin_nxt;
  logic [2:0][SCR_W-1:0]  scr1_r, diff2_r, diff_nxt, scr_nxt;
  logic [2:0][PROD_W-1:0] prod3_r, prod_nxt;
  logic [F:0]             mid1_r, mid2_r;
  logic [2:0][CLR_W-1:0]  to1_r, to2_r, to3_r, chan_nxt;
  logic                   done1_r, done2_r, done3_r;
  out_item_t              out_item_r;

  logic [PROD_W:0]        rnd;
  logic [OUT_W-1:0]       sum, clp, rsum;
  logic [CLR_W+3:0]       rq;

  always_comb begin
    rnd  = '0;
    sum  = '0;
    clp  = '0;
    rsum = '0;
    rq   = '0;
    for (int c = 0; c < 3; c++) begin
      lin_nxt[c] = LIN_W'(in_from[c]) * LIN_W'(ONE - in_w)
                 + LIN_W'(in_to[c]) * LIN_W'(in_w);
      scr_nxt[c] = ((SCR_W'(in_from[c]) + SCR_W'(in_to[c])) << F) - SCR_W'(in_q[c]);
      diff_nxt[c] = (scr1_r[c] > SCR_W'(lin1_r[c])) ?
                    scr1_r[c] - SCR_W'(lin1_r[c]) : '0;
      prod_nxt[c] = PROD_W'(diff2_r[c]) * PROD_W'(mid2_r);

      rnd  = (PROD_W+1)'(prod3_r[c]) + ((PROD_W+1)'(1) << (F - 1));
      sum  = OUT_W'(lin3_r[c]) + OUT_W'(rnd[PROD_W:F]);
      clp  = (sum > LIM) ? LIM : sum;
      rsum = clp + HALF;
      rq   = rsum[OUT_W-1:F];
      if (done3_r) begin
        chan_nxt[c] = to3_r[c];
      end else begin
        chan_nxt[c] = (rq > (CLR_W+4)'(CLR_MAX)) ? CLR_MAX : rq[CLR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin1_r  <= lin_nxt;
      scr1_r  <= scr_nxt;
      mid1_r  <= in_mid;
      to1_r   <= in_to;
      done1_r <= in_done;

      diff2_r <= diff_nxt;
      lin2_r  <= lin1_r;
      mid2_r  <= mid1_r;
      to2_r   <= to1_r;
      done2_r <= done1_r;

      prod3_r <= prod_nxt;
      lin3_r  <= lin2_r;
      to3_r   <= to2_r;
      done3_r <= done2_r;

      out_item_r.out_red   <= chan_nxt[0];
      out_item_r.out_green <= chan_nxt[1];
      out_item_r.out_blue  <= chan_nxt[2];
      out_item_r.done_res  <= done3_r;
    end
  end

  assign out_valid = vld_r[3];
  assign out_item  = out_item_r;

endmodule

// ===== rtl/eased_screen_crossfade_pixel.sv =====
// The divider pipeline takes one quotient bit per stage over 16 + FRACTION_BITS stages.
// Throughput: one item per cycle; out_stall freezes every stage, in_stall follows it.
// Reset: clears all valid bits; duration returns to 1000 ms, easing to quintic.
// Top level: APB registers, input stage, divider, weight and blend pipelines.
// Depends on ecf_pkg, ecf_div_pipe, ecf_weight, ecf_blend.
module eased_screen_crossfade_pixel #(
  parameter int unsigned FRACTION_BITS = ecf_pkg::FRAC_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ecf_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ecf_pkg::out_item_t                out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ecf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ecf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ecf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ecf_pkg::*;

  localparam int unsigned F       = FRACTION_BITS;
  localparam int unsigned QC_W    = CLR_W + F;
  localparam int unsigned QM      = F / CLR_W;
  localparam int unsigned QS      = F % CLR_W;
  localparam int unsigned DSIDE_W = 2 + 12*CLR_W;
  localparam int unsigned WSIDE_W = 1 + 6*CLR_W + 3*QC_W;

  // configuration registers
  logic [DUR_W-1:0] dur_r, dur_nxt;
  logic             mode_r, mode_nxt;
  logic             cfg_wr;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    dur_nxt  = dur_r;
    mode_nxt = mode_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_DURATION: dur_nxt  = pwdata[DUR_W-1:0];
        REG_MODE:     mode_nxt = pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DURATION: prdata = APB_DATA_W'(dur_r);
      REG_MODE:     prdata = APB_DATA_W'(mode_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r  <= DUR_RESET;
      mode_r <= MODE_RESET;
    end else begin
      dur_r  <= dur_nxt;
      mode_r <= mode_nxt;
    end
  end

  // whole pipeline moves unless a finished item is held at the output
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input stage: completion compare, from*to split into quotient and
  // remainder by the color maximum
  logic [2:0][CLR_W-1:0]   from_in, to_in;
  logic [2:0][2*CLR_W-1:0] ft_nxt;
  logic [2:0][CLR_W-1:0]   ftq_nxt, ftr_nxt;
  logic                    vld0_r, done0_r, mode0_r;
  logic [DUR_W-1:0]        elapsed0_r, dur0_r;
  logic [2:0][CLR_W-1:0]   from0_r, to0_r;
  logic [2:0][CLR_W-1:0]   ftq0_r, ftr0_r;

  assign from_in = {in_item.from_blue, in_item.from_green, in_item.from_red};
  assign to_in   = {in_item.to_blue, in_item.to_green, in_item.to_red};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ft_nxt[c]  = (2*CLR_W)'(from_in[c]) * (2*CLR_W)'(to_in[c]);
      // x / (2^n - 1) for x up to (2^n - 1)^2 is (x + 1 + (x >> n)) >> n
      ftq_nxt[c] = CLR_W'((ft_nxt[c] + (2*CLR_W)'(1) + (ft_nxt[c] >> CLR_W)) >> CLR_W);
      ftr_nxt[c] = CLR_W'(ft_nxt[c] - (2*CLR_W)'(ftq_nxt[c]) * (2*CLR_W)'(CLR_MAX));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      elapsed0_r <= in_item.elapsed_ms;
      dur0_r     <= dur_r;
      mode0_r    <= mode_r;
      done0_r    <= in_item.elapsed_ms >= dur_r;
      from0_r    <= from_in;
      to0_r      <= to_in;
      ftq0_r     <= ftq_nxt;
      ftr0_r     <= ftr_nxt;
    end
  end

  // division
  logic                  div_valid;
  logic [F-1:0]          div_p;
  logic [2:0][QC_W-1:0]  div_q;
  logic [DSIDE_W-1:0]    div_side;
  logic                  mode_d, done_d;
  logic [2:0][CLR_W-1:0] from_d, to_d, ftq_d, ftr_d;

  ecf_div_pipe #(
    .FRACTION_BITS (F),
    .SIDE_W        (DSIDE_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (vld0_r),
    .in_elapsed (elapsed0_r),
    .in_dur     (dur0_r),
    .in_side    ({mode0_r, done0_r, from0_r, to0_r, ftq0_r, ftr0_r}),
    .out_valid  (div_valid),
    .out_p      (div_p),
    .out_side   (div_side)
  );

  assign {mode_d, done_d, from_d, to_d, ftq_d, ftr_d} = div_side;

  // round(from*to*2^F / color max) from quotient q and remainder r of from*to;
  // since 2^CLR_W is one above the divisor, r*2^F/max repeats r every CLR_W bits
  function automatic logic [QC_W-1:0] scr_quot(logic [CLR_W-1:0] q, logic [CLR_W-1:0] r);
    logic [2*CLR_W-1:0] sh, hi;
    logic [CLR_W-1:0]   lo;
    logic [QC_W-1:0]    rep;
    sh  = (2*CLR_W)'(r) << QS;
    hi  = (sh + (2*CLR_W)'(1) + (sh >> CLR_W)) >> CLR_W;
    lo  = CLR_W'(sh - hi * (2*CLR_W)'(CLR_MAX));
    rep = '0;
    for (int i = 0; i < QM; i++) begin
      rep = rep | (QC_W'(lo) << (i * CLR_W));
    end
    // the half-divisor rounding term carries once lo reaches its top bit
    return (QC_W'(q) << F) + (QC_W'(hi) << (QM * CLR_W)) + rep + QC_W'(lo[CLR_W-1]);
  endfunction

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div_q[c] = scr_quot(ftq_d[c], ftr_d[c]);
    end
  end

  // weight
  logic                  wgt_valid;
  logic [F:0]            wgt_w, wgt_mid;
  logic [WSIDE_W-1:0]    wgt_side;
  logic                  done_w;
  logic [2:0][CLR_W-1:0] from_w, to_w;
  logic [2:0][QC_W-1:0]  q_w;

  ecf_weight #(
    .FRACTION_BITS (F),
    .SIDE_W        (WSIDE_W)
  ) u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_p      (div_p),
    .in_mode   (mode_d),
    .in_side   ({done_d, from_d, to_d, div_q}),
    .out_valid (wgt_valid),
    .out_w     (wgt_w),
    .out_mid   (wgt_mid),
    .out_side  (wgt_side)
  );

  assign {done_w, from_w, to_w, q_w} = wgt_side;

  ecf_blend #(
    .FRACTION_BITS (F)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (wgt_valid),
    .in_w      (wgt_w),
    .in_mid    (wgt_mid),
    .in_from   (from_w),
    .in_to     (to_w),
    .in_q      (q_w),
    .in_done   (done_w),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/ecf_checker.sv =====
// Port-level checks for the crossfade pixel block, bound to the top level.
// Depends on ecf_pkg and eased_screen_crossfade_pixel.
module ecf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input ecf_pkg::out_item_t                out_item,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [ecf_pkg::APB_ADDR_W-1:0]    paddr,
  input logic [ecf_pkg::APB_DATA_W-1:0]    pwdata,
  input logic [ecf_pkg::APB_DATA_W-1:0]    prdata,
  input logic                              pready
);
  import ecf_pkg::*;

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // input side stalls exactly when a finished item is held
  a_stall_link: assert property (@(posedge clk) in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the held output item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held output item changed");

  // duration register reads back what was last written
  a_dur_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(psel && penable && pwrite && pready && !paddr[2]) && !paddr[2]
    |-> prdata[DUR_W-1:0] == $past(pwdata[DUR_W-1:0]))
    else $error("duration readback mismatch");

endmodule

bind eased_screen_crossfade_pixel ecf_checker u_ecf_checker (.*);
